// ===== rtl/core/mp2a_pkg.sv =====
// Package for the 2x2 max pooling block with argmax.
// Holds size defaults, configuration register indexes and reset values.
// Used by max_pool_2x2_argmax; no dependencies.
`timescale 1ns / 1ps

package mp2a_pkg;

    // Default build sizes
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Coordinate outputs are fixed at ten bits
    localparam int IDX_BITS = 10;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_HEIGHT  = 2'd2;

    // Register reset values
    localparam logic                     POOL_ENABLE_RST = 1'b1;
    localparam logic [CFG_DATA_BITS-1:0] MAP_WIDTH_RST   = 11'd28;
    localparam logic [CFG_DATA_BITS-1:0] MAP_HEIGHT_RST  = 11'd28;

endpackage

// ===== rtl/core/mp2a_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the pooling line store; no dependencies.
`timescale 1ns / 1ps

module mp2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/max_pool_2x2_argmax.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------------
// input    | in_valid / in_stall   | raw_value, activated_value
// output   | out_valid / out_stall | raw_out, activated_out, col_index, row_index,
//          |                       | last_of_map
// config   | cfg_write             | cfg_index, cfg_data
//
// One pixel is taken per cycle while in_stall is low. A result passes through
// the stage 1 register, loaded with the line-store read, then the output queue.
// The line store (one entry per column pair) is written on even window rows
// and read on odd rows; no clearing pass, entries are valid once written.
// Reset clears counters, registers and the output queue. A two-deep output
// queue keeps input flowing at full rate while out_stall is low.
// Depends on mp2a_pkg and mp2a_ram.
`timescale 1ns / 1ps

module max_pool_2x2_argmax #(
    parameter int MAX_WIDTH  = mp2a_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mp2a_pkg::MAX_HEIGHT_DEF,
    parameter int VALUE_BITS = mp2a_pkg::VALUE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration
    input  logic                                    cfg_write,
    input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    // input pixels
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [VALUE_BITS-1:0]            raw_value,
    input  logic signed [VALUE_BITS-1:0]            activated_value,
    // results
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [VALUE_BITS-1:0]            raw_out,
    output logic signed [VALUE_BITS-1:0]            activated_out,
    output logic [mp2a_pkg::IDX_BITS-1:0]           col_index,
    output logic [mp2a_pkg::IDX_BITS-1:0]           row_index,
    output logic                                    last_of_map
);

    import mp2a_pkg::*;

    localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int CXW        = ((WW > CW) ? WW : CW) + 1;
    localparam int RXW        = ((HW > RW) ? HW : RW) + 1;
    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int MEM_W      = 2 * VALUE_BITS + 1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] raw;
        logic signed [VALUE_BITS-1:0] act;
        logic [CW-1:0]                col;
        logic [RW-1:0]                row;
        logic                         last;
    } res_t;

    // Configuration registers
    logic                     pool_enable_reg;
    logic [CFG_DATA_BITS-1:0] map_width_reg;
    logic [CFG_DATA_BITS-1:0] map_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_enable_reg <= POOL_ENABLE_RST;
            map_width_reg   <= MAP_WIDTH_RST;
            map_height_reg  <= MAP_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POOL_ENABLE: pool_enable_reg <= cfg_data[0];
                CFG_MAP_WIDTH:   map_width_reg   <= cfg_data;
                CFG_MAP_HEIGHT:  map_height_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Map size saturated to 2 .. MAX
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (32'(map_width_reg) < 32'd2)
            w_eff = WW'(2);
        else if (32'(map_width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(map_width_reg);

        if (32'(map_height_reg) < 32'd2)
            h_eff = HW'(2);
        else if (32'(map_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(map_height_reg);
    end

    // Handshake and queue bookkeeping
    logic in_accept;
    logic pop;
    logic head_valid_reg, head_valid_next;
    logic spare_valid_reg, spare_valid_next;
    logic s1_valid_reg;
    logic [1:0] fill;

    assign pop       = head_valid_reg && !out_stall;
    assign fill      = 2'(head_valid_reg) + 2'(spare_valid_reg) + 2'(s1_valid_reg) - 2'(pop);
    assign in_stall  = (fill >= 2'd2);
    assign in_accept = in_valid && !in_stall;

    // Position of this pixel, wrapping stale counters after a size change
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  c_at;
    logic [RW-1:0]  r_at;
    logic [RXW-1:0] r_tmp;
    logic [CXW-1:0] c_nx;
    logic [RXW-1:0] r_nx;

    always_comb
    begin
        if (CXW'(col_reg) >= CXW'(w_eff))
        begin
            c_at  = '0;
            r_tmp = RXW'(row_reg) + RXW'(1);
        end
        else
        begin
            c_at  = col_reg;
            r_tmp = RXW'(row_reg);
        end
        if (r_tmp >= RXW'(h_eff))
            r_at = '0;
        else
            r_at = RW'(r_tmp);

        // Position of the next pixel
        c_nx = CXW'(c_at) + CXW'(1);
        r_nx = RXW'(r_at);
        if (c_nx >= CXW'(w_eff))
        begin
            col_next = '0;
            r_nx     = RXW'(r_at) + RXW'(1);
        end
        else
        begin
            col_next = CW'(c_nx);
        end
        if (r_nx >= RXW'(h_eff))
            row_next = '0;
        else
            row_next = RW'(r_nx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Horizontal pair compare: odd column wins only when strictly greater
    logic signed [VALUE_BITS-1:0] pair_raw_reg;
    logic signed [VALUE_BITS-1:0] pair_act_reg;
    logic                         odd_wins;
    logic signed [VALUE_BITS-1:0] win_raw;
    logic signed [VALUE_BITS-1:0] win_act;
    logic                         is_odd_col;
    logic                         is_odd_row;

    assign is_odd_col = c_at[0];
    assign is_odd_row = r_at[0];
    assign odd_wins   = activated_value > pair_act_reg;
    assign win_raw    = odd_wins ? raw_value : pair_raw_reg;
    assign win_act    = odd_wins ? activated_value : pair_act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_raw_reg <= '0;
            pair_act_reg <= '0;
        end
        else if (in_accept && pool_enable_reg && !is_odd_col)
        begin
            pair_raw_reg <= raw_value;
            pair_act_reg <= activated_value;
        end
    end

    // Line store: pair winners of the upper window row. A read of an entry
    // follows its write by at least one even-column pixel, so no forwarding.
    logic             mem_wr;
    logic             mem_rd;
    logic [AW-1:0]    mem_addr;
    logic [MEM_W-1:0] mem_wdata;
    logic [MEM_W-1:0] mem_rdata;

    assign mem_addr  = AW'(c_at >> 1);
    assign mem_wr    = in_accept && pool_enable_reg && is_odd_col && !is_odd_row;
    assign mem_rd    = in_accept && pool_enable_reg && is_odd_col && is_odd_row;
    assign mem_wdata = {win_raw, win_act, odd_wins};

    mp2a_ram #(
        .WIDTH (MEM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata),
        .rd_en   (mem_rd),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    // Stage 1 load: pass-through pixel or pooled lower-row pair
    logic   s1_load;
    logic   s1_cmp_reg;
    res_t   s1_reg;
    res_t   s1_next;
    logic   last_pass;
    logic   last_pool;

    assign last_pass = (WW'(c_at) == w_eff - WW'(1)) && (HW'(r_at) == h_eff - HW'(1));
    assign last_pool = (WW'(c_at) == (w_eff & ~WW'(1)) - WW'(1)) &&
                       (HW'(r_at) == (h_eff & ~HW'(1)) - HW'(1));
    assign s1_load   = in_accept && (!pool_enable_reg || (is_odd_col && is_odd_row));

    always_comb
    begin
        if (!pool_enable_reg)
        begin
            s1_next.raw  = raw_value;
            s1_next.act  = activated_value;
            s1_next.col  = c_at;
            s1_next.row  = r_at;
            s1_next.last = last_pass;
        end
        else
        begin
            s1_next.raw  = win_raw;
            s1_next.act  = win_act;
            s1_next.col  = (c_at & ~CW'(1)) | CW'(odd_wins);
            s1_next.row  = r_at;
            s1_next.last = last_pool;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg     <= s1_next;
            s1_cmp_reg <= pool_enable_reg;
        end
    end

    // Vertical compare against the stored upper-row winner
    logic signed [VALUE_BITS-1:0] up_raw;
    logic signed [VALUE_BITS-1:0] up_act;
    logic                         up_odd;
    logic                         keep_up;
    res_t                         s1_res;

    assign {up_raw, up_act, up_odd} = mem_rdata;
    assign keep_up = s1_cmp_reg && !(s1_reg.act > up_act);

    always_comb
    begin
        s1_res = s1_reg;
        if (keep_up)
        begin
            s1_res.raw = up_raw;
            s1_res.act = up_act;
            s1_res.col = (s1_reg.col & ~CW'(1)) | CW'(up_odd);
            s1_res.row = s1_reg.row - RW'(1);
        end
    end

    // Two-entry output queue: head drives the port, spare absorbs a stall
    res_t head_reg, head_next;
    res_t spare_reg, spare_next;

    always_comb
    begin
        head_next        = head_reg;
        spare_next       = spare_reg;
        head_valid_next  = head_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (pop)
        begin
            if (spare_valid_reg)
            begin
                head_next        = spare_reg;
                spare_next       = s1_res;
                spare_valid_next = s1_valid_reg;
            end
            else
            begin
                head_next       = s1_res;
                head_valid_next = s1_valid_reg;
            end
        end
        else if (s1_valid_reg)
        begin
            if (!head_valid_reg)
            begin
                head_next       = s1_res;
                head_valid_next = 1'b1;
            end
            else
            begin
                spare_next       = s1_res;
                spare_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    // Output ports
    assign out_valid     = head_valid_reg;
    assign raw_out       = head_reg.raw;
    assign activated_out = head_reg.act;
    assign col_index     = IDX_BITS'(head_reg.col);
    assign row_index     = IDX_BITS'(head_reg.row);
    assign last_of_map   = head_reg.last;

endmodule

// ===== verif/max_pool_2x2_argmax_test.sv =====
// Self-checking testbench for max_pool_2x2_argmax: random valid/stall traffic on both
// channels, with a scoreboard class that predicts every pooled window and pass-through echo.
// Depends on mp2a_pkg and the max_pool_2x2_argmax RTL.
`timescale 1ns / 1ps

localparam int VB = mp2a_pkg::VALUE_BITS_DEF;
localparam int IB = mp2a_pkg::IDX_BITS;
localparam int CDB = mp2a_pkg::CFG_DATA_BITS;
localparam int LINE_SLOTS = mp2a_pkg::MAX_WIDTH_DEF / 2;

typedef struct {
    bit signed [VB-1:0] raw;
    bit signed [VB-1:0] act;
    bit [IB-1:0]        col;
    bit [IB-1:0]        row;
    bit                 last;
} winner_t;

// Tracks map position, pair and upper-row winners, and queues the expected results
class pool_scoreboard;
    bit                 pool_en;
    bit [CDB-1:0]       width_reg;
    bit [CDB-1:0]       height_reg;
    int unsigned        col_pos;
    int unsigned        row_pos;
    bit signed [VB-1:0] pair_raw;
    bit signed [VB-1:0] pair_act;
    bit signed [VB-1:0] upper_raw [LINE_SLOTS];
    bit signed [VB-1:0] upper_act [LINE_SLOTS];
    bit                 upper_odd [LINE_SLOTS];
    winner_t            expected_winners [$];
    int                 errors;
    int                 pixels;
    int                 windows;
    int                 echoes;

    function new();
        pool_en    = mp2a_pkg::POOL_ENABLE_RST;
        width_reg  = mp2a_pkg::MAP_WIDTH_RST;
        height_reg = mp2a_pkg::MAP_HEIGHT_RST;
    endfunction

    function int unsigned clamp_size(bit [CDB-1:0] v, int unsigned maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function void apply_register(bit [mp2a_pkg::CFG_INDEX_BITS-1:0] idx, bit [CDB-1:0] data);
        case (idx)
            mp2a_pkg::CFG_POOL_ENABLE: pool_en = data[0];
            mp2a_pkg::CFG_MAP_WIDTH:   width_reg = data;
            mp2a_pkg::CFG_MAP_HEIGHT:  height_reg = data;
            default: ;
        endcase
    endfunction

    // Pixels still needed to bring the counters back to the top-left corner
    function int unsigned pixels_to_map_end();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        w = clamp_size(width_reg, mp2a_pkg::MAX_WIDTH_DEF);
        h = clamp_size(height_reg, mp2a_pkg::MAX_HEIGHT_DEF);
        c = col_pos;
        r = row_pos;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        if (c == 0 && r == 0) return 0;
        return w * h - (r * w + c);
    endfunction

    // One accepted pixel transaction; queues a result when the pixel closes a window
    function void note_pixel(bit signed [VB-1:0] raw, bit signed [VB-1:0] act);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        int unsigned        slot;
        bit signed [VB-1:0] win_raw;
        bit signed [VB-1:0] win_act;
        bit                 win_odd;
        winner_t            e;
        w = clamp_size(width_reg, mp2a_pkg::MAX_WIDTH_DEF);
        h = clamp_size(height_reg, mp2a_pkg::MAX_HEIGHT_DEF);
        c = col_pos;
        r = row_pos;
        pixels++;
        // counters left outside a shrunken map wrap first
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;

        if (!pool_en) begin
            e.raw  = raw;
            e.act  = act;
            e.col  = IB'(c);
            e.row  = IB'(r);
            e.last = (c == w - 1) && (r == h - 1);
            expected_winners.push_back(e);
            echoes++;
        end else if (c % 2 == 0) begin
            pair_raw = raw;
            pair_act = act;
        end else begin
            slot = (c / 2) % LINE_SLOTS;
            // later pixel must be strictly greater to win
            if (act > pair_act) begin
                win_raw = raw;
                win_act = act;
                win_odd = 1'b1;
            end else begin
                win_raw = pair_raw;
                win_act = pair_act;
                win_odd = 1'b0;
            end
            if (r % 2 == 0) begin
                upper_raw[slot] = win_raw;
                upper_act[slot] = win_act;
                upper_odd[slot] = win_odd;
            end else begin
                if (win_act > upper_act[slot]) begin
                    e.raw = win_raw;
                    e.act = win_act;
                    e.col = IB'(c - 1 + win_odd);
                    e.row = IB'(r);
                end else begin
                    e.raw = upper_raw[slot];
                    e.act = upper_act[slot];
                    e.col = IB'(c - 1 + upper_odd[slot]);
                    e.row = IB'(r - 1);
                end
                // odd last row/column never complete a window
                e.last = (c == w - w % 2 - 1) && (r == h - h % 2 - 1);
                expected_winners.push_back(e);
                windows++;
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function void compare_field(string name, logic [VB-1:0] expv, logic [VB-1:0] gotv);
        if (gotv !== expv) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, expv, gotv);
        end
    endfunction

    // One accepted result transaction against the oldest expectation
    function void check_result(logic [VB-1:0] raw, logic [VB-1:0] act,
                               logic [IB-1:0] col, logic [IB-1:0] row, logic last);
        winner_t e;
        if (expected_winners.size() == 0) begin
            errors++;
            $display("%0t: expected no result, got raw %h act %h col %0d row %0d",
                     $time, raw, act, col, row);
            return;
        end
        e = expected_winners.pop_front();
        compare_field("raw_out", e.raw, raw);
        compare_field("activated_out", e.act, act);
        compare_field("col_index", e.col, col);
        compare_field("row_index", e.row, row);
        compare_field("last_of_map", e.last, last);
    endfunction
endclass

module max_pool_2x2_argmax_test;
    import mp2a_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_PIXELS = 1000;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam bit signed [VB-1:0] Q_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam bit signed [VB-1:0] Q_MAX = {1'b0, {(VB-1){1'b1}}};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VB-1:0]      raw_value;
    logic signed [VB-1:0]      activated_value;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VB-1:0]      raw_out;
    logic signed [VB-1:0]      activated_out;
    logic [IB-1:0]             col_index;
    logic [IB-1:0]             row_index;
    logic                      last_of_map;

    pool_scoreboard     sb;
    bit                 calm;
    int                 stall_left;
    int                 idle_cycles;
    int                 configs;
    bit signed [VB-1:0] prev_act;

    max_pool_2x2_argmax i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_value       (raw_value),
        .activated_value (activated_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .raw_out         (raw_out),
        .activated_out   (activated_out),
        .col_index       (col_index),
        .row_index       (row_index),
        .last_of_map     (last_of_map)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int gap_len();
        if (calm || $urandom_range(0, 99) < 60) return 0;
        return pause_len();
    endfunction

    // Extremes, near-zero values that tie often, and full-range noise
    function automatic bit signed [VB-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            4, 5: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [CDB-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return CDB'($urandom_range(0, 1));
        if (r == 1) return CDB'($urandom_range(13, 24));
        return CDB'($urandom_range(2, 12));
    endfunction

    // Receiver: random stall stretches, none in calm phases
    always @(posedge clk)
    begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 70) begin
            out_stall <= 1'b0;
        end else begin
            stall_left = pause_len() - 1;
            out_stall <= 1'b1;
        end
    end

    // Transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_pixel(raw_value, activated_value);
            if (out_valid && !out_stall)
                sb.check_result(raw_out, activated_out, col_index, row_index, last_of_map);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CDB-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_register(idx, data);
    endtask

    // Sender holds off until every expected result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_winners.size() != 0);
    endtask

    // Idle point: results drained, then the pipeline left to empty with margin
    task automatic settle();
        drain_results();
        repeat (6) @(posedge clk);
    endtask

    task automatic send_pixel(bit signed [VB-1:0] raw, bit signed [VB-1:0] act);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        raw_value       <= raw;
        activated_value <= act;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_pixel();
        bit signed [VB-1:0] act;
        // repeat the last activated value now and then to force ties
        act = ($urandom_range(0, 7) == 0) ? prev_act : pick_value();
        prev_act = act;
        send_pixel(pick_value(), act);
    endtask

    task automatic configure(bit pool, bit [CDB-1:0] w, bit [CDB-1:0] h);
        int           n;
        bit [CDB-1:0] mode_word;
        settle();
        // pooling must start at the top-left, so finish a partial pass-through map
        n = sb.pixels_to_map_end();
        if (pool && n != 0) begin
            repeat (n) send_random_pixel();
            settle();
        end
        mode_word = CDB'($urandom);
        mode_word[0] = pool;
        write_register(CFG_POOL_ENABLE, mode_word);
        write_register(CFG_MAP_WIDTH, w);
        write_register(CFG_MAP_HEIGHT, h);
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_SPARE, CDB'($urandom));
        cfg_write <= 1'b0;
        configs++;
    endtask

    task automatic run_phase(bit pool, bit [CDB-1:0] w, bit [CDB-1:0] h, int n);
        configure(pool, w, h);
        calm = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            send_random_pixel();
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        bit signed [VB-1:0] act4x4 [16];
        bit signed [VB-1:0] act2x2 [4];
        bit signed [VB-1:0] act3x3 [9];
        bit                 pool;
        bit [CDB-1:0]       w;
        bit [CDB-1:0]       h;
        int                 cw;
        int                 ch;
        int                 n;
        int                 random_pixels;

        sb = new();
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= CFG_POOL_ENABLE;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        raw_value       <= '0;
        activated_value <= '0;
        out_stall       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // 4x4 pooled: all-minimum tie, top-right tie win, bottom-left and bottom-right wins
        act4x4 = '{Q_MIN, Q_MIN, 5, 7,
                   Q_MIN, Q_MIN, 7, 3,
                   0, -1, -1, -1,
                   1, 0, -2, Q_MAX};
        configure(1'b1, 11'd4, 11'd4);
        for (int i = 0; i < 16; i++) begin
            send_pixel((i == 0) ? Q_MAX : (i == 15) ? Q_MIN : i * 32'h0101_0101 ^ 32'hA5A5_0000,
                       act4x4[i]);
            if (i == 7)
                drain_results();
        end

        // sizes below two saturate to a 2x2 pass-through map
        act2x2 = '{Q_MAX, Q_MIN, 0, -1};
        configure(1'b0, 11'd0, 11'd1);
        for (int i = 0; i < 4; i++)
            send_pixel(~act2x2[i], act2x2[i]);

        // 3x3 pooled: odd column and row give nothing, one window with the last flag
        act3x3 = '{2, 2, 9,
                   3, 2, 9,
                   9, 9, 9};
        configure(1'b1, 11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(i * 32'h1357_9BDF, act3x3[i]);

        // Random phases of small maps
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            pool = ($urandom_range(0, 9) < 7);
            w = pick_size();
            h = pick_size();
            cw = (w < 2) ? 2 : w;
            ch = (h < 2) ? 2 : h;
            if (pool)
                n = $urandom_range(1, 2) * cw * ch;
            else
                n = $urandom_range(1, cw * ch + cw);
            run_phase(pool, w, h, n);
            random_pixels += n;
        end

        // oversized map saturates to the largest size; a short pass-through stretch
        run_phase(1'b0, 11'd2047, 11'd2047, 64);

        settle();
        $display("covered %0d pixels in, %0d pooled windows and %0d pass-through echoes",
                 sb.pixels, sb.windows, sb.echoes);
        $display("over %0d configurations, maps from 2x2 to 24x24 plus a saturated 1024x1024",
                 configs);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== max_pool_2x2_argmax.f =====
rtl/core/mp2a_pkg.sv
rtl/core/mp2a_ram.sv
rtl/core/max_pool_2x2_argmax.sv
verif/max_pool_2x2_argmax_test.sv
